@@ rtl/dpt32_pkg.sv @@
package dpt32_pkg;

  localparam int unsigned NUM_WITNESS = 3;
  localparam int unsigned WIT_IDX_W = $clog2(NUM_WITNESS);
  localparam int unsigned WIT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPLIT,
    S_BASE,
    S_W_BASE,
    S_POW,
    S_W_MUL,
    S_W_SQP,
    S_CHK,
    S_W_SQ,
    S_FINISH
  } state_e;

  // witness bases, exact for every value below 4759123141
  function automatic logic [WIT_W-1:0] witness_base(input logic [WIT_IDX_W-1:0] idx);
    logic [WIT_W-1:0] val;
    case (idx)
      2'd0:    val = 6'd2;
      2'd1:    val = 6'd7;
      2'd2:    val = 6'd61;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/dpt32_cand_if.sv @@
interface dpt32_cand_if #(
  parameter int unsigned NUMBER_BITS = 31
);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

@@ rtl/dpt32_res_if.sv @@
interface dpt32_res_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink (input valid, input prime_flag, output ready);
endinterface

@@ rtl/dpt32_mulmod.sv @@
module dpt32_mulmod #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] a_i,
  input  logic [NUMBER_BITS-1:0] b_i,
  input  logic [NUMBER_BITS-1:0] n_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [NUMBER_BITS-1:0] rem_o
);

  localparam int unsigned PW = 2 * NUMBER_BITS;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam logic [CW-1:0] STEPS = CW'(PW);

  logic [PW-1:0]          prod_q;
  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic [NUMBER_BITS:0]   trial;

  // restoring reduction, one product bit per cycle, msb first
  always_comb begin
    trial = {rem_q, prod_q[PW-1]};
    if (trial >= {1'b0, n_i}) begin
      rem_d = NUMBER_BITS'(trial - {1'b0, n_i});
    end else begin
      rem_d = trial[NUMBER_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PW'(a_i) * PW'(b_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      prod_q <= {prod_q[PW-2:0], 1'b0};
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/deterministic_prime_test_32_unit.sv @@
// channel  | dir | payload                        | handshake
// cand_i   | in  | candidate [NUMBER_BITS-1:0]    | valid / ready
// res_o    | out | prime_flag                     | valid / ready
//
// one item is in work at a time; cand_i.ready is high only while the sequencer idles.
// each modular product runs through the shared multiply/reduce unit;
// zero, one, even values and the bases go straight to the finish state.
// a finished result waits in the output register while the next item is taken.
// rst_ni clears the sequencer and the output valid asynchronously.
module deterministic_prime_test_32_unit #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dpt32_cand_if.sink          cand_i,
  dpt32_res_if.source         res_o
);

  localparam int unsigned NB = NUMBER_BITS;
  localparam int unsigned IW = dpt32_pkg::WIT_IDX_W;
  localparam logic [IW-1:0] LAST_WIT = IW'(dpt32_pkg::NUM_WITNESS - 1);

  dpt32_pkg::state_e state_q, state_d;

  logic [NB-1:0] n_q, n_d;
  logic [NB-1:0] d_q, d_d;
  logic [NB-1:0] e_q, e_d;
  logic [NB-1:0] acc_q, acc_d;
  logic [NB-1:0] sq_q, sq_d;
  logic [NB-1:0] t_q, t_d;
  logic [IW-1:0] wit_q, wit_d;
  logic          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic          out_bit_q, out_bit_d;

  logic          mm_start, mm_busy, mm_done;
  logic [NB-1:0] mm_a, mm_b, mm_rem;

  logic [NB-1:0] cand;
  logic [NB-1:0] n_m1;
  logic          in_fire;

  assign cand    = cand_i.candidate;
  assign n_m1    = n_q - NB'(1);
  assign in_fire = cand_i.valid && cand_i.ready;

  dpt32_mulmod #(
    .NUMBER_BITS(NB)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .n_i    (n_q),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .rem_o  (mm_rem)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    e_d         = e_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    t_d         = t_q;
    wit_d       = wit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_bit_d   = out_bit_q;
    mm_start    = 1'b0;
    mm_a        = acc_q;
    mm_b        = sq_q;

    unique case (state_q)
      dpt32_pkg::S_IDLE: begin
        if (in_fire) begin
          n_d   = cand;
          d_d   = cand - NB'(1);
          wit_d = '0;
          if (cand <= NB'(1)) begin
            res_d   = 1'b0;
            state_d = dpt32_pkg::S_FINISH;
          end else if (cand == NB'(2) || cand == NB'(7) || cand == NB'(61)) begin
            res_d   = 1'b1;
            state_d = dpt32_pkg::S_FINISH;
          end else if (!cand[0]) begin
            res_d   = 1'b0;
            state_d = dpt32_pkg::S_FINISH;
          end else begin
            state_d = dpt32_pkg::S_SPLIT;
          end
        end
      end
      dpt32_pkg::S_SPLIT: begin
        // strip factors of two from n-1
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[NB-1:1]};
        end else begin
          state_d = dpt32_pkg::S_BASE;
        end
      end
      dpt32_pkg::S_BASE: begin
        // base mod n through the shared unit, times one
        mm_start = 1'b1;
        mm_a     = NB'(dpt32_pkg::witness_base(wit_q));
        mm_b     = NB'(1);
        state_d  = dpt32_pkg::S_W_BASE;
      end
      dpt32_pkg::S_W_BASE: begin
        if (mm_done) begin
          sq_d    = mm_rem;
          acc_d   = NB'(1);
          e_d     = d_q;
          state_d = dpt32_pkg::S_POW;
        end
      end
      dpt32_pkg::S_POW: begin
        mm_start = 1'b1;
        if (e_q[0]) begin
          state_d = dpt32_pkg::S_W_MUL;
        end else begin
          mm_a    = sq_q;
          state_d = dpt32_pkg::S_W_SQP;
        end
      end
      dpt32_pkg::S_W_MUL: begin
        if (mm_done) begin
          acc_d = mm_rem;
          if (e_q == NB'(1)) begin
            t_d     = d_q;
            state_d = dpt32_pkg::S_CHK;
          end else begin
            mm_start = 1'b1;
            mm_a     = sq_q;
            state_d  = dpt32_pkg::S_W_SQP;
          end
        end
      end
      dpt32_pkg::S_W_SQP: begin
        if (mm_done) begin
          sq_d    = mm_rem;
          e_d     = {1'b0, e_q[NB-1:1]};
          state_d = dpt32_pkg::S_POW;
        end
      end
      dpt32_pkg::S_CHK: begin
        if (t_q != n_m1 && acc_q != NB'(1) && acc_q != n_m1) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          mm_b     = acc_q;
          state_d  = dpt32_pkg::S_W_SQ;
        end else if (acc_q != n_m1 && !t_q[0]) begin
          // this base witnesses a composite
          res_d   = 1'b0;
          state_d = dpt32_pkg::S_FINISH;
        end else if (wit_q == LAST_WIT) begin
          res_d   = 1'b1;
          state_d = dpt32_pkg::S_FINISH;
        end else begin
          wit_d   = wit_q + IW'(1);
          state_d = dpt32_pkg::S_BASE;
        end
      end
      dpt32_pkg::S_W_SQ: begin
        if (mm_done) begin
          acc_d   = mm_rem;
          t_d     = {t_q[NB-2:0], 1'b0};
          state_d = dpt32_pkg::S_CHK;
        end
      end
      dpt32_pkg::S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_q;
          state_d     = dpt32_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dpt32_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpt32_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      wit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wit_q       <= wit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    e_q       <= e_d;
    acc_q     <= acc_d;
    sq_q      <= sq_d;
    t_q       <= t_d;
    res_q     <= res_d;
    out_bit_q <= out_bit_d;
  end

  assign cand_i.ready     = (state_q == dpt32_pkg::S_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.prime_flag = out_bit_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !cand_i.ready)
    else $error("input taken while an item is still in work");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_busy)
    else $error("shared unit started while busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == dpt32_pkg::S_W_BASE || state_q == dpt32_pkg::S_W_MUL ||
                 state_q == dpt32_pkg::S_W_SQP || state_q == dpt32_pkg::S_W_SQ))
    else $error("product finished with no sequencer waiting");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpt32_pkg::S_FINISH && state_d == dpt32_pkg::S_IDLE) |=> res_o.valid)
    else $error("result lost on leaving finish");

endmodule
